// File: src/assert_macros.svh
// Assertion macros shared by the counted key hash multiset modules.
// Each macro builds one labeled concurrent assertion that is disabled
// while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every rising clock edge.
`define CKHM_ASSERT_ALWAYS(label, clk_sig, rstn_sig, expr, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (expr)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define CKHM_ASSERT_IMPLY(label, clk_sig, rstn_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |-> (cons)) else $error(msg);

`endif

// File: src/ckhm_pkg.sv
// ============================================================================
// ckhm_pkg
// Shared constants, result codes and controller/datapath interface types
// for the counted key hash multiset.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package ckhm_pkg;

    // Key and result field geometry.
    localparam int KEY_W      = 40;
    localparam int KEY_NBYTES = KEY_W / 8;
    localparam int IDX_W      = 3;
    localparam int COUNT_W    = 24;
    localparam int DIST_OUT_W = 12;
    localparam int STATUS_W   = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Operation codes on the func input.
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

    // One way of a bucket.
    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
    } slot_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             clr;
        logic             load;
        logic             mul;
        logic             rec;
        logic             red;
        logic             upd;
        logic [IDX_W-1:0] step;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic             clr_last;
        logic [IDX_W-1:0] key_len;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: src/counted_key_hash_multiset.sv
// ============================================================================
// counted_key_hash_multiset - counting hash multiset of short text keys
// Start is taken only while idle; busy stays high from a taken start until
// the bucket update, and done is registered from the update. Each byte pair costs
// three passes through the hash unit (multiply, reciprocal, reduce).
// Reset: a clearing pass over all buckets with busy high; no result stalls.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module counted_key_hash_multiset #(
    parameter int BUCKETS   = 500,
    parameter int WAYS      = 4,
    parameter int KEY_BYTES = 5
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              func,
    input  wire logic [ckhm_pkg::KEY_W-1:0]        key,
    output logic                                   done,
    output logic                                   changed,
    output logic [ckhm_pkg::COUNT_W-1:0]           key_count,
    output logic [ckhm_pkg::DIST_OUT_W-1:0]        distinct_keys,
    output logic [ckhm_pkg::STATUS_W-1:0]          status
);

    ckhm_pkg::dp_cmd_t  cmd;
    ckhm_pkg::dp_stat_t stat;

    // Sequencer.
    ckhm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    // Hash unit, bucket memory and result registers.
    ckhm_datapath #(
        .BUCKETS   (BUCKETS),
        .WAYS      (WAYS),
        .KEY_BYTES (KEY_BYTES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .func          (func),
        .key           (key),
        .done          (done),
        .changed       (changed),
        .key_count     (key_count),
        .distinct_keys (distinct_keys),
        .status        (status)
    );

endmodule

`default_nettype wire

// File: src/ckhm_ctrl.sv
// ============================================================================
// ckhm_ctrl
// Sequencer for the multiset: runs the bucket clearing pass after reset,
// steps the hash over the key bytes and issues the bucket update.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ckhm_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    output ckhm_pkg::dp_cmd_t       cmd,
    input  wire ckhm_pkg::dp_stat_t stat
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_HASH   = 3'd2;
    localparam logic [2:0] S_RECIP  = 3'd3;
    localparam logic [2:0] S_REDUCE = 3'd4;
    localparam logic [2:0] S_UPDATE = 3'd5;

    logic [2:0]                     state_reg;
    logic [2:0]                     state_next;
    logic [ckhm_pkg::IDX_W-1:0]     step_reg;
    logic [ckhm_pkg::IDX_W-1:0]     step_next;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    step_next  = ckhm_pkg::IDX_W'(1);
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                // One hash step per remaining byte pair, then the bucket lookup.
                if (step_reg < stat.key_len)
                begin
                    cmd.mul    = 1'b1;
                    state_next = S_RECIP;
                end
                else
                begin
                    state_next = S_UPDATE;
                end
            end
            S_RECIP:
            begin
                cmd.rec    = 1'b1;
                state_next = S_REDUCE;
            end
            S_REDUCE:
            begin
                cmd.red    = 1'b1;
                step_next  = step_reg + ckhm_pkg::IDX_W'(1);
                state_next = S_HASH;
            end
            S_UPDATE:
            begin
                cmd.upd    = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // At most one datapath command is active in any cycle.
    `CKHM_ASSERT_ALWAYS(a_cmd_onehot0, clk, rst_n, ($onehot0({cmd.clr, cmd.load, cmd.mul, cmd.rec, cmd.red, cmd.upd})), "more than one datapath command active")
    // The reciprocal multiply always consumes a product from the previous cycle.
    `CKHM_ASSERT_IMPLY(a_rec_after_mul, clk, rst_n, cmd.rec, $past(cmd.mul), "reciprocal step without a product")
    // A hash step only ever pairs bytes that lie inside the key.
    `CKHM_ASSERT_IMPLY(a_step_in_key, clk, rst_n, cmd.mul, ((step_reg != '0) && (step_reg < stat.key_len)), "hash step outside the key")

endmodule

`default_nettype wire

// File: src/ckhm_datapath.sv
// ============================================================================
// ckhm_datapath
// Key normalization, multiply and reciprocal-reduce hash unit, bucket memory
// with compare and write-back, and the result registers.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ckhm_datapath #(
    parameter int BUCKETS   = 500,
    parameter int WAYS      = 4,
    parameter int KEY_BYTES = 5
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire ckhm_pkg::dp_cmd_t                 cmd,
    output ckhm_pkg::dp_stat_t                     stat,
    input  wire logic                              func,
    input  wire logic [ckhm_pkg::KEY_W-1:0]        key,
    output logic                                   done,
    output logic                                   changed,
    output logic [ckhm_pkg::COUNT_W-1:0]           key_count,
    output logic [ckhm_pkg::DIST_OUT_W-1:0]        distinct_keys,
    output logic [ckhm_pkg::STATUS_W-1:0]          status
);

    localparam int H_W       = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int SUM_W     = ((H_W > 8) ? H_W : 8) + 1;
    localparam int P_W       = SUM_W + 8;
    localparam int RECIP_SH  = 32;
    localparam int MUL_W     = P_W + RECIP_SH;
    localparam logic [31:0] RECIP = 32'((64'd1 << RECIP_SH) / BUCKETS);
    localparam int EFF_BYTES = (KEY_BYTES < ckhm_pkg::KEY_NBYTES) ?
                               KEY_BYTES : ckhm_pkg::KEY_NBYTES;
    localparam int DIST_W    = $clog2(BUCKETS * WAYS + 1);
    localparam int BKT_LAST  = BUCKETS - 1;

    localparam int KW = ckhm_pkg::KEY_W;
    localparam int CW = ckhm_pkg::COUNT_W;
    localparam int IW = ckhm_pkg::IDX_W;
    localparam int NB = ckhm_pkg::KEY_NBYTES;

    // Item registers.
    logic                   func_reg;
    logic [7:0]             kb_reg [NB];
    logic [IW-1:0]          len_reg;
    logic [KW-1:0]          key_norm;

    // Hash unit.
    logic [H_W-1:0]         h_reg;
    logic [P_W-1:0]         prod_reg;
    logic [P_W-1:0]         q_reg;
    logic [7:0]             cur_byte;
    logic [7:0]             prev_byte;
    logic [SUM_W-1:0]       sum_hb;
    logic [P_W-1:0]         prod_next;
    logic [MUL_W-1:0]       recip_prod;
    logic [P_W-1:0]         qb;
    logic [P_W-1:0]         rem;
    logic [P_W-1:0]         rem_fix;

    // Normalization.
    logic [7:0]             norm_b [NB];
    logic [IW-1:0]          norm_len;
    logic                   alive;

    // Bucket memory.
    ckhm_pkg::slot_t [WAYS-1:0] bucket_mem [BUCKETS];
    ckhm_pkg::slot_t [WAYS-1:0] row_rd_reg;
    ckhm_pkg::slot_t [WAYS-1:0] row_new;
    ckhm_pkg::slot_t [WAYS-1:0] mem_wdata;
    logic [H_W-1:0]         mem_waddr;
    logic                   mem_we;
    logic [H_W-1:0]         clr_addr_reg;

    // Lookup and update.
    logic [WAYS-1:0]        hit_sel;
    logic [WAYS-1:0]        free_sel;
    logic                   hit_found;
    logic                   free_found;
    logic [CW-1:0]          hit_cnt;
    logic [CW-1:0]          cnt_inc;
    logic [CW-1:0]          cnt_dec;
    logic                   upd_we;
    logic                   res_changed;
    logic [CW-1:0]          res_count;
    logic [ckhm_pkg::STATUS_W-1:0] res_status;
    logic [DIST_W-1:0]      dist_next;

    // Results.
    logic [DIST_W-1:0]      distinct_reg;
    logic                   done_reg;
    logic                   changed_reg;
    logic [CW-1:0]          count_reg;
    logic [ckhm_pkg::STATUS_W-1:0] status_reg;
    logic [31:0]            dist_wide;

    // Keep the bytes before the first zero byte, up to the key length limit.
    always_comb
    begin
        alive    = 1'b1;
        norm_len = '0;
        for (int n = 0; n < NB; n++)
        begin
            if ((n < EFF_BYTES) && alive && (key[8*n +: 8] != 8'd0))
            begin
                norm_b[n] = key[8*n +: 8];
                norm_len  = norm_len + IW'(1);
            end
            else
            begin
                norm_b[n] = 8'd0;
                alive     = 1'b0;
            end
        end
    end

    // Normalized key as one word for the way compare.
    always_comb
    begin
        for (int n = 0; n < NB; n++)
        begin
            key_norm[8*n +: 8] = kb_reg[n];
        end
    end

    // Hash step: product, reciprocal quotient, then remainder with one correction.
    assign cur_byte   = kb_reg[cmd.step];
    assign prev_byte  = kb_reg[cmd.step - IW'(1)];
    assign sum_hb     = SUM_W'(h_reg) + SUM_W'(cur_byte);
    assign prod_next  = P_W'(sum_hb) * P_W'(prev_byte);
    assign recip_prod = MUL_W'(prod_reg) * MUL_W'(RECIP);
    assign qb         = q_reg * P_W'(BUCKETS);
    assign rem        = prod_reg - qb;
    assign rem_fix    = (rem >= P_W'(BUCKETS)) ? (rem - P_W'(BUCKETS)) : rem;

    // Find the first matching way and the first free way of the bucket.
    always_comb
    begin
        hit_found  = 1'b0;
        free_found = 1'b0;
        hit_sel    = '0;
        free_sel   = '0;
        hit_cnt    = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (row_rd_reg[w].valid)
            begin
                if (!hit_found && (row_rd_reg[w].key == key_norm))
                begin
                    hit_found  = 1'b1;
                    hit_sel[w] = 1'b1;
                    hit_cnt    = row_rd_reg[w].count;
                end
            end
            else if (!free_found)
            begin
                free_found  = 1'b1;
                free_sel[w] = 1'b1;
            end
        end
    end

    assign cnt_inc = (hit_cnt == ckhm_pkg::COUNT_MAX) ? hit_cnt : (hit_cnt + CW'(1));
    assign cnt_dec = hit_cnt - CW'(1);

    // Build the updated bucket row and the result fields.
    always_comb
    begin
        row_new     = row_rd_reg;
        upd_we      = 1'b0;
        res_changed = 1'b0;
        res_count   = '0;
        res_status  = ckhm_pkg::ST_OK;
        dist_next   = distinct_reg;
        if (func_reg == ckhm_pkg::FUNC_INSERT)
        begin
            if (hit_found)
            begin
                upd_we    = 1'b1;
                res_count = cnt_inc;
                for (int w = 0; w < WAYS; w++)
                begin
                    if (hit_sel[w])
                    begin
                        row_new[w].count = cnt_inc;
                    end
                end
            end
            else if (free_found)
            begin
                upd_we      = 1'b1;
                res_changed = 1'b1;
                res_count   = CW'(1);
                dist_next   = distinct_reg + DIST_W'(1);
                for (int w = 0; w < WAYS; w++)
                begin
                    if (free_sel[w])
                    begin
                        row_new[w].valid = 1'b1;
                        row_new[w].key   = key_norm;
                        row_new[w].count = CW'(1);
                    end
                end
            end
            else
            begin
                res_status = ckhm_pkg::ST_FULL;
            end
        end
        else
        begin
            if (hit_found)
            begin
                upd_we    = 1'b1;
                res_count = cnt_dec;
                for (int w = 0; w < WAYS; w++)
                begin
                    if (hit_sel[w])
                    begin
                        row_new[w].count = cnt_dec;
                        if (cnt_dec == '0)
                        begin
                            row_new[w].valid = 1'b0;
                        end
                    end
                end
                if (cnt_dec == '0)
                begin
                    res_changed = 1'b1;
                    if (distinct_reg != '0)
                    begin
                        dist_next = distinct_reg - DIST_W'(1);
                    end
                end
            end
            else
            begin
                res_status = ckhm_pkg::ST_ABSENT;
            end
        end
    end

    // Memory write port: clearing pass or bucket write-back.
    assign mem_we    = cmd.clr | (cmd.upd & upd_we);
    assign mem_waddr = cmd.clr ? clr_addr_reg : h_reg;
    assign mem_wdata = cmd.clr ? '0 : row_new;

    // Bucket memory with registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bucket_mem[mem_waddr] <= mem_wdata;
        end
        row_rd_reg <= bucket_mem[h_reg];
    end

    // Control state of the datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg        <= '0;
            clr_addr_reg <= '0;
            distinct_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.upd;
            if (cmd.clr)
            begin
                clr_addr_reg <= clr_addr_reg + H_W'(1);
            end
            if (cmd.load)
            begin
                h_reg <= '0;
            end
            else if (cmd.red)
            begin
                h_reg <= rem_fix[H_W-1:0];
            end
            if (cmd.upd)
            begin
                distinct_reg <= dist_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            len_reg  <= norm_len;
            for (int n = 0; n < NB; n++)
            begin
                kb_reg[n] <= norm_b[n];
            end
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.rec)
        begin
            q_reg <= recip_prod[RECIP_SH +: P_W];
        end
        if (cmd.upd)
        begin
            changed_reg <= res_changed;
            count_reg   <= res_count;
            status_reg  <= res_status;
        end
    end

    assign stat.clr_last = (clr_addr_reg == H_W'(BKT_LAST));
    assign stat.key_len  = len_reg;

    assign dist_wide     = 32'(distinct_reg);
    assign done          = done_reg;
    assign changed       = changed_reg;
    assign key_count     = count_reg;
    assign distinct_keys = dist_wide[ckhm_pkg::DIST_OUT_W-1:0];
    assign status        = status_reg;

    // The reduced hash always addresses an existing bucket.
    `CKHM_ASSERT_ALWAYS(a_bucket_range, clk, rst_n, (32'(h_reg) < BUCKETS), "bucket index out of range")
    // A change in the set only comes with a successful operation.
    `CKHM_ASSERT_IMPLY(a_changed_ok, clk, rst_n, (done_reg && changed_reg), (status_reg == ckhm_pkg::ST_OK), "change reported with error status")
    // A dropped or ignored operation reports a zero count and no change.
    `CKHM_ASSERT_IMPLY(a_error_zero, clk, rst_n, (done_reg && (status_reg != ckhm_pkg::ST_OK)), ((count_reg == '0) && !changed_reg), "error result carries a count")

endmodule

`default_nettype wire

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// Counted key hash multiset testbench
// Drives insert and delete commands into counted_key_hash_multiset and checks
// every result against a behavioral multiset model. The stimulus opens with
// directed cases: the empty key, bytes after the end of a key, a full bucket,
// an absent delete and extreme key values. Random traffic follows over a
// small pool of colliding keys, with some fully random noise keys mixed in.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int BUCKETS      = 500;
    localparam int WAYS         = 4;
    localparam int KEY_BYTES    = 5;
    localparam int SLOTS        = BUCKETS * WAYS;
    localparam int POOL_SIZE    = 36;
    localparam int PHASE_ITEMS  = 580;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 4000;

    // One pending command and the idle chance applied before it is driven.
    typedef struct {
        logic                       op;
        logic [ckhm_pkg::KEY_W-1:0] key;
        int                         idle_pct;
    } op_item_t;

    // The result fields of one transfer.
    typedef struct {
        logic                            changed;
        logic [ckhm_pkg::COUNT_W-1:0]    key_count;
        logic [ckhm_pkg::DIST_OUT_W-1:0] distinct_keys;
        logic [ckhm_pkg::STATUS_W-1:0]   status;
    } op_result_t;

    logic                            clk   = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            func  = ckhm_pkg::FUNC_INSERT;
    logic [ckhm_pkg::KEY_W-1:0]      key   = '0;
    logic                            busy;
    logic                            done;
    logic                            changed;
    logic [ckhm_pkg::COUNT_W-1:0]    key_count;
    logic [ckhm_pkg::DIST_OUT_W-1:0] distinct_keys;
    logic [ckhm_pkg::STATUS_W-1:0]   status;

    op_item_t   cmd_queue[$];
    op_result_t expected_results[$];
    int         fail_count  = 0;
    int         stall_count = 0;

    // Model copy of the multiset contents.
    bit                           slot_used[SLOTS];
    logic [ckhm_pkg::KEY_W-1:0]   slot_key[SLOTS];
    logic [ckhm_pkg::COUNT_W-1:0] slot_count[SLOTS];
    int                           distinct_total = 0;

    // Key pool for the random traffic.
    logic [ckhm_pkg::KEY_W-1:0] key_pool[POOL_SIZE];
    int                         pool_len[POOL_SIZE];

    counted_key_hash_multiset #(
        .BUCKETS   (BUCKETS),
        .WAYS      (WAYS),
        .KEY_BYTES (KEY_BYTES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .key           (key),
        .done          (done),
        .changed       (changed),
        .key_count     (key_count),
        .distinct_keys (distinct_keys),
        .status        (status)
    );

    // Clock and a single reset at the start of the run.
    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Applies one command to the model multiset and returns its result.
    task automatic multiset_apply(input logic op, input logic [ckhm_pkg::KEY_W-1:0] raw,
                                  output op_result_t res);
        logic [ckhm_pkg::KEY_W-1:0] norm;
        int len;
        int i;
        int h;
        int base;
        int hit_way;
        int free_way;
        int s;
        norm = '0;
        len = 0;
        while (len < KEY_BYTES && raw[8*len +: 8] != 8'h00)
        begin
            norm[8*len +: 8] = raw[8*len +: 8];
            len++;
        end
        // Rolling hash over byte pairs selects the bucket.
        h = 0;
        for (i = 1; i < len; i++)
        begin
            h = ((h + int'(norm[8*i +: 8])) * int'(norm[8*(i-1) +: 8])) % BUCKETS;
        end
        base = h * WAYS;
        hit_way = -1;
        free_way = -1;
        for (i = 0; i < WAYS; i++)
        begin
            if (slot_used[base + i])
            begin
                if (hit_way < 0 && slot_key[base + i] == norm)
                    hit_way = i;
            end
            else if (free_way < 0)
            begin
                free_way = i;
            end
        end
        res.changed = 1'b0;
        res.key_count = '0;
        res.status = ckhm_pkg::ST_OK;
        if (op == ckhm_pkg::FUNC_INSERT)
        begin
            if (hit_way >= 0)
            begin
                s = base + hit_way;
                if (slot_count[s] != ckhm_pkg::COUNT_MAX)
                    slot_count[s] = slot_count[s] + ckhm_pkg::COUNT_W'(1);
                res.key_count = slot_count[s];
            end
            else if (free_way >= 0)
            begin
                s = base + free_way;
                slot_used[s] = 1'b1;
                slot_key[s] = norm;
                slot_count[s] = ckhm_pkg::COUNT_W'(1);
                res.key_count = ckhm_pkg::COUNT_W'(1);
                res.changed = 1'b1;
                distinct_total++;
            end
            else
            begin
                res.status = ckhm_pkg::ST_FULL;
            end
        end
        else
        begin
            if (hit_way >= 0)
            begin
                s = base + hit_way;
                slot_count[s] = slot_count[s] - ckhm_pkg::COUNT_W'(1);
                res.key_count = slot_count[s];
                if (slot_count[s] == '0)
                begin
                    slot_used[s] = 1'b0;
                    res.changed = 1'b1;
                    if (distinct_total > 0)
                        distinct_total--;
                end
            end
            else
            begin
                res.status = ckhm_pkg::ST_ABSENT;
            end
        end
        res.distinct_keys = distinct_total[ckhm_pkg::DIST_OUT_W-1:0];
    endtask

    task automatic queue_op(input logic op, input logic [ckhm_pkg::KEY_W-1:0] k,
                            input int pct);
        op_item_t item;
        item.op = op;
        item.key = k;
        item.idle_pct = pct;
        cmd_queue.push_back(item);
    endtask

    // Builds a key of the given length from non-zero random bytes.
    function automatic logic [ckhm_pkg::KEY_W-1:0] random_key(input int len);
        logic [ckhm_pkg::KEY_W-1:0] k;
        int i;
        k = '0;
        for (i = 0; i < len; i++)
            k[8*i +: 8] = 8'($urandom_range(1, 255));
        return k;
    endfunction

    // Driver: holds start until the transfer is taken, then loads the next item.
    always @(posedge clk)
    begin
        op_result_t predicted;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                multiset_apply(func, key, predicted);
                expected_results.push_back(predicted);
            end
            if (!start || !busy)
            begin
                if (cmd_queue.size() > 0 &&
                    $urandom_range(0, 99) >= cmd_queue[0].idle_pct)
                begin
                    start <= 1'b1;
                    func  <= cmd_queue[0].op;
                    key   <= cmd_queue[0].key;
                    cmd_queue.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each strobed result with the oldest expectation.
    always @(posedge clk)
    begin
        op_result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result strobed with no transfer outstanding");
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (changed !== want.changed)
                begin
                    $error("changed: expected %0d, actual %0d", want.changed, changed);
                    fail_count++;
                end
                if (key_count !== want.key_count)
                begin
                    $error("key_count: expected %0d, actual %0d", want.key_count, key_count);
                    fail_count++;
                end
                if (distinct_keys !== want.distinct_keys)
                begin
                    $error("distinct_keys: expected %0d, actual %0d",
                           want.distinct_keys, distinct_keys);
                    fail_count++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: ends the run after a long stretch with no transfer and no result.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("counted_key_hash_multiset regression: fail");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int i;
        int phase;
        int pct;
        int pick;
        int n;
        logic op;
        logic [ckhm_pkg::KEY_W-1:0] k;
        logic [63:0] rnd;

        // Pool: single-byte keys all land in bucket 0, and six two-byte keys
        // share bucket 20, so full buckets come up often.
        for (i = 0; i < 10; i++)
        begin
            key_pool[i] = random_key(1);
            pool_len[i] = 1;
        end
        key_pool[10] = 40'h0A02;
        key_pool[11] = 40'h020A;
        key_pool[12] = 40'h0504;
        key_pool[13] = 40'h0405;
        key_pool[14] = 40'h1401;
        key_pool[15] = 40'h0114;
        for (i = 10; i < 16; i++)
            pool_len[i] = 2;
        for (i = 16; i < 30; i++)
        begin
            key_pool[i] = random_key(2);
            pool_len[i] = 2;
        end
        for (i = 30; i < POOL_SIZE; i++)
        begin
            pool_len[i] = $urandom_range(3, KEY_BYTES);
            key_pool[i] = random_key(pool_len[i]);
        end

        // Directed: empty key, trailing bytes, full bucket 0, absent delete,
        // extreme keys and a zero byte in the middle of a key.
        queue_op(ckhm_pkg::FUNC_DELETE, 40'h0000000000, 7);
        queue_op(ckhm_pkg::FUNC_INSERT, 40'h0000000000, 7);
        queue_op(ckhm_pkg::FUNC_INSERT, 40'hFFFFFFFF00, 7);
        queue_op(ckhm_pkg::FUNC_INSERT, 40'h0000000061, 7);
        queue_op(ckhm_pkg::FUNC_INSERT, 40'hABCDEF0062, 7);
        queue_op(ckhm_pkg::FUNC_INSERT, 40'h0000000063, 7);
        queue_op(ckhm_pkg::FUNC_INSERT, 40'h0000000064, 7);
        queue_op(ckhm_pkg::FUNC_DELETE, 40'h0000000061, 7);
        queue_op(ckhm_pkg::FUNC_DELETE, 40'h0000000061, 7);
        queue_op(ckhm_pkg::FUNC_INSERT, 40'h0000000064, 7);
        queue_op(ckhm_pkg::FUNC_INSERT, 40'hFFFFFFFFFF, 7);
        queue_op(ckhm_pkg::FUNC_DELETE, 40'hFFFFFFFFFF, 7);
        queue_op(ckhm_pkg::FUNC_INSERT, 40'h0101010101, 7);
        queue_op(ckhm_pkg::FUNC_INSERT, 40'h8000000001, 7);
        queue_op(ckhm_pkg::FUNC_INSERT, 40'h4142004344, 7);
        queue_op(ckhm_pkg::FUNC_INSERT, 40'h0000004344, 7);
        queue_op(ckhm_pkg::FUNC_DELETE, 40'h5500004344, 7);
        queue_op(ckhm_pkg::FUNC_DELETE, 40'h0000000000, 7);
        queue_op(ckhm_pkg::FUNC_DELETE, 40'h0000000000, 7);
        queue_op(ckhm_pkg::FUNC_INSERT, 40'h7F80C0E0F0, 7);
        queue_op(ckhm_pkg::FUNC_DELETE, 40'h7F80C0E0F0, 7);

        // Random traffic in three idle phases: light, heavy, then none.
        for (phase = 0; phase < 3; phase++)
        begin
            pct = (phase == 0) ? 7 : ((phase == 1) ? 48 : 0);
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                rnd = {$urandom, $urandom};
                if ($urandom_range(0, 99) < 10)
                begin
                    // Noise: any 40-bit key, either operation.
                    op = rnd[63];
                    k = rnd[ckhm_pkg::KEY_W-1:0];
                end
                else
                begin
                    pick = $urandom_range(0, POOL_SIZE - 1);
                    n = pool_len[pick];
                    k = key_pool[pick];
                    // Garbage after the terminating zero byte keeps the same key.
                    if (n < KEY_BYTES - 1 && $urandom_range(0, 3) == 0)
                        k = k | (rnd[ckhm_pkg::KEY_W-1:0] &
                                 ~((40'h1 << (8 * (n + 1))) - 40'h1));
                    op = ($urandom_range(0, 99) < 55) ? ckhm_pkg::FUNC_INSERT
                                                       : ckhm_pkg::FUNC_DELETE;
                end
                queue_op(op, k, pct);
            end
        end

        // Wait until every command is taken and every result has arrived.
        while (cmd_queue.size() != 0 || start || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("counted_key_hash_multiset regression: pass");
        else
            $display("counted_key_hash_multiset regression: fail");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/ckhm_pkg.sv
src/ckhm_ctrl.sv
src/ckhm_datapath.sv
src/counted_key_hash_multiset.sv
dv/testbench.sv
